// File: sv/lmt_pkg.sv
package lmt_pkg;

    // Widths of the item fields and of the internal counters.
    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int DOTS_W   = 6;
    localparam int CNT_W    = 9;
    localparam int LINE_W   = 8;
    localparam int MODE_W   = 2;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    // LCD modes as held in status bits 1:0.
    localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_VRAM   = 2'd3;

    // Status register and LCDC bit positions.
    localparam int STAT_COIN_BIT   = 2;
    localparam int STAT_HBLANK_EN  = 3;
    localparam int STAT_VBLANK_EN  = 4;
    localparam int STAT_OAM_EN     = 5;
    localparam int STAT_COIN_EN    = 6;
    localparam int LCDC_ON_BIT     = 7;

    // Phase lengths in dots and frame geometry in lines.
    localparam logic [CNT_W-1:0]  OAM_DOTS      = 9'd80;
    localparam logic [CNT_W-1:0]  VRAM_DOTS     = 9'd172;
    localparam logic [CNT_W-1:0]  HBLANK_DOTS   = 9'd204;
    localparam logic [CNT_W-1:0]  LINE_DOTS     = 9'd456;
    localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0] TOTAL_LINES   = 8'd154;

    // Register map.
    localparam logic [ADDR_W-1:0] ADDR_LCDC = 16'hFF40;
    localparam logic [ADDR_W-1:0] ADDR_STAT = 16'hFF41;
    localparam logic [ADDR_W-1:0] ADDR_SCY  = 16'hFF42;
    localparam logic [ADDR_W-1:0] ADDR_SCX  = 16'hFF43;
    localparam logic [ADDR_W-1:0] ADDR_LY   = 16'hFF44;
    localparam logic [ADDR_W-1:0] ADDR_LYC  = 16'hFF45;
    localparam logic [ADDR_W-1:0] ADDR_BGP  = 16'hFF47;
    localparam logic [ADDR_W-1:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [ADDR_W-1:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [ADDR_W-1:0] ADDR_WY   = 16'hFF4A;
    localparam logic [ADDR_W-1:0] ADDR_WX   = 16'hFF4B;

    // Reset values and the unmapped read value.
    localparam logic [BYTE_W-1:0] BGP_RESET   = 8'hFC;
    localparam logic [BYTE_W-1:0] OBP_RESET   = 8'hFF;
    localparam logic [BYTE_W-1:0] UNMAPPED_RD = 8'hFF;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the accepted item
        logic step;      // advance the display by one dot
        logic exec;      // perform a register write
        logic load_out;  // load the result register
    } lmt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_tick;
        logic disp_on;
        logic remain_zero;
    } lmt_sts_t;

endpackage

// File: sv/lmt_ctrl.sv
module lmt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  lmt_pkg::lmt_sts_t sts,
    output lmt_pkg::lmt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencing: accept, step dots one per cycle, then hand over the result.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.op_tick && sts.disp_on && !sts.remain_zero) begin
                    cmd.step = 1'b1;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result register is full from its load until the transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_RUN))
        else $error("accepted item did not start");

    a_step_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (sts.op_tick && sts.disp_on && !sts.remain_zero))
        else $error("dot step outside an active tick");

endmodule

// File: sv/lmt_datapath.sv
module lmt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lmt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  lmt_pkg::lmt_cmd_t               cmd,
    output lmt_pkg::lmt_sts_t               sts,
    output logic [lmt_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Captured item.
    logic [lmt_pkg::OPCODE_W-1:0] op_reg;
    logic [lmt_pkg::ADDR_W-1:0]   addr_reg;
    logic [lmt_pkg::BYTE_W-1:0]   wdata_reg;
    logic [lmt_pkg::DOTS_W-1:0]   remain_reg;

    // Request accumulators for the running tick.
    logic vb_acc_reg;
    logic st_acc_reg;

    // LCD registers and timing state.
    logic [lmt_pkg::BYTE_W-1:0] lcdc_reg;
    logic [lmt_pkg::BYTE_W-1:0] stat_reg;
    logic [lmt_pkg::BYTE_W-1:0] scy_reg;
    logic [lmt_pkg::BYTE_W-1:0] scx_reg;
    logic [lmt_pkg::LINE_W-1:0] ly_reg;
    logic [lmt_pkg::BYTE_W-1:0] lyc_reg;
    logic [lmt_pkg::BYTE_W-1:0] wy_reg;
    logic [lmt_pkg::BYTE_W-1:0] wx_reg;
    logic [lmt_pkg::BYTE_W-1:0] bgp_reg;
    logic [lmt_pkg::BYTE_W-1:0] obp0_reg;
    logic [lmt_pkg::BYTE_W-1:0] obp1_reg;
    logic [lmt_pkg::CNT_W-1:0]  dot_reg;

    // Result register.
    logic [lmt_pkg::BYTE_W-1:0] rd_out_reg;
    logic                       vb_out_reg;
    logic                       st_out_reg;

    // One-dot step results.
    logic [lmt_pkg::CNT_W-1:0]  dot_next;
    logic [lmt_pkg::LINE_W-1:0] ly_next;
    logic [lmt_pkg::MODE_W-1:0] mode_next;
    logic                       coin_next;
    logic                       vb_hit;
    logic                       st_hit;
    logic [lmt_pkg::CNT_W-1:0]  dot_inc;
    logic [lmt_pkg::LINE_W-1:0] ly_inc;
    logic [lmt_pkg::MODE_W-1:0] mode_cur;
    logic                       coin_inc;
    logic                       coin_zero;
    logic [lmt_pkg::BYTE_W-1:0] rd_value;

    assign sts.op_tick     = (op_reg == lmt_pkg::OP_TICK);
    assign sts.disp_on     = lcdc_reg[lmt_pkg::LCDC_ON_BIT];
    assign sts.remain_zero = (remain_reg == '0);

    assign m_tdata = {{(lmt_pkg::M_TDATA_W - lmt_pkg::BYTE_W - 2){1'b0}},
                      st_out_reg, vb_out_reg, rd_out_reg};

    assign mode_cur  = stat_reg[1:0];
    assign dot_inc   = dot_reg + 1'b1;
    assign ly_inc    = ly_reg + 1'b1;
    assign coin_inc  = (ly_inc == lyc_reg);
    assign coin_zero = (lyc_reg == '0);

    // Advance the mode sequencer by one dot.
    always_comb begin
        dot_next  = dot_inc;
        ly_next   = ly_reg;
        mode_next = mode_cur;
        coin_next = stat_reg[lmt_pkg::STAT_COIN_BIT];
        vb_hit    = 1'b0;
        st_hit    = 1'b0;
        case (mode_cur)
            lmt_pkg::MODE_OAM: begin
                if (dot_inc >= lmt_pkg::OAM_DOTS) begin
                    dot_next  = '0;
                    mode_next = lmt_pkg::MODE_VRAM;
                end
            end
            lmt_pkg::MODE_VRAM: begin
                if (dot_inc >= lmt_pkg::VRAM_DOTS) begin
                    dot_next  = '0;
                    st_hit    = stat_reg[lmt_pkg::STAT_HBLANK_EN];
                    mode_next = lmt_pkg::MODE_HBLANK;
                end
            end
            lmt_pkg::MODE_HBLANK: begin
                if (dot_inc >= lmt_pkg::HBLANK_DOTS) begin
                    dot_next  = '0;
                    ly_next   = ly_inc;
                    coin_next = coin_inc;
                    if (ly_inc >= lmt_pkg::VISIBLE_LINES) begin
                        st_hit    = stat_reg[lmt_pkg::STAT_VBLANK_EN] ||
                                    (coin_inc && stat_reg[lmt_pkg::STAT_COIN_EN]);
                        vb_hit    = 1'b1;
                        mode_next = lmt_pkg::MODE_VBLANK;
                    end else begin
                        st_hit    = stat_reg[lmt_pkg::STAT_OAM_EN] ||
                                    (coin_inc && stat_reg[lmt_pkg::STAT_COIN_EN]);
                        mode_next = lmt_pkg::MODE_OAM;
                    end
                end
            end
            default: begin
                if (dot_inc >= lmt_pkg::LINE_DOTS) begin
                    dot_next = '0;
                    if (ly_inc >= lmt_pkg::TOTAL_LINES) begin
                        ly_next   = '0;
                        coin_next = coin_zero;
                        st_hit    = stat_reg[lmt_pkg::STAT_OAM_EN] ||
                                    (coin_zero && stat_reg[lmt_pkg::STAT_COIN_EN]);
                        mode_next = lmt_pkg::MODE_OAM;
                    end else begin
                        ly_next   = ly_inc;
                        coin_next = coin_inc;
                        st_hit    = coin_inc && stat_reg[lmt_pkg::STAT_COIN_EN];
                    end
                end
            end
        endcase
    end

    // Register read decode; ticks and writes return zero.
    always_comb begin
        rd_value = '0;
        if (op_reg == lmt_pkg::OP_READ) begin
            case (addr_reg)
                lmt_pkg::ADDR_LCDC: rd_value = lcdc_reg;
                lmt_pkg::ADDR_STAT: rd_value = stat_reg;
                lmt_pkg::ADDR_SCY:  rd_value = scy_reg;
                lmt_pkg::ADDR_SCX:  rd_value = scx_reg;
                lmt_pkg::ADDR_LY:   rd_value = ly_reg;
                lmt_pkg::ADDR_LYC:  rd_value = lyc_reg;
                lmt_pkg::ADDR_BGP:  rd_value = bgp_reg;
                lmt_pkg::ADDR_OBP0: rd_value = obp0_reg;
                lmt_pkg::ADDR_OBP1: rd_value = obp1_reg;
                lmt_pkg::ADDR_WY:   rd_value = wy_reg;
                lmt_pkg::ADDR_WX:   rd_value = wx_reg;
                default:            rd_value = lmt_pkg::UNMAPPED_RD;
            endcase
        end
    end

    // Item capture, dot count and request accumulation.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg     <= s_tdata[1:0];
            addr_reg   <= s_tdata[17:2];
            wdata_reg  <= s_tdata[25:18];
            remain_reg <= s_tdata[31:26];
            vb_acc_reg <= 1'b0;
            st_acc_reg <= 1'b0;
        end else if (cmd.step) begin
            remain_reg <= remain_reg - 1'b1;
            vb_acc_reg <= vb_acc_reg || vb_hit;
            st_acc_reg <= st_acc_reg || st_hit;
        end
    end

    // LCD register file and timing state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcdc_reg <= '0;
            stat_reg <= '0;
            scy_reg  <= '0;
            scx_reg  <= '0;
            ly_reg   <= '0;
            lyc_reg  <= '0;
            wy_reg   <= '0;
            wx_reg   <= '0;
            bgp_reg  <= lmt_pkg::BGP_RESET;
            obp0_reg <= lmt_pkg::OBP_RESET;
            obp1_reg <= lmt_pkg::OBP_RESET;
            dot_reg  <= '0;
        end else if (cmd.step) begin
            dot_reg  <= dot_next;
            ly_reg   <= ly_next;
            stat_reg <= {stat_reg[7:3], coin_next, mode_next};
        end else if (cmd.exec && (op_reg == lmt_pkg::OP_WRITE)) begin
            case (addr_reg)
                lmt_pkg::ADDR_LCDC: lcdc_reg <= wdata_reg;
                lmt_pkg::ADDR_STAT: stat_reg <= {1'b0, wdata_reg[6:3], stat_reg[2:0]};
                lmt_pkg::ADDR_SCY:  scy_reg  <= wdata_reg;
                lmt_pkg::ADDR_SCX:  scx_reg  <= wdata_reg;
                lmt_pkg::ADDR_LYC:  lyc_reg  <= wdata_reg;
                lmt_pkg::ADDR_BGP:  bgp_reg  <= wdata_reg;
                lmt_pkg::ADDR_OBP0: obp0_reg <= wdata_reg;
                lmt_pkg::ADDR_OBP1: obp1_reg <= wdata_reg;
                lmt_pkg::ADDR_WY:   wy_reg   <= wdata_reg;
                lmt_pkg::ADDR_WX:   wx_reg   <= wdata_reg;
                default: begin
                end
            endcase
        end
    end

    // Result register, loaded when the item is finished.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            rd_out_reg <= rd_value;
            vb_out_reg <= vb_acc_reg;
            st_out_reg <= st_acc_reg;
        end
    end

    a_vblank_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_cur == lmt_pkg::MODE_VBLANK) |-> (ly_reg >= lmt_pkg::VISIBLE_LINES))
        else $error("VBlank mode on a visible line");

    a_dot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dot_reg < lmt_pkg::LINE_DOTS)
        else $error("dot counter beyond line length");

    a_stat_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat_reg[7])
        else $error("status bit 7 set");

endmodule

// File: sv/lcd_mode_timing_and_registers_top.sv
// LCD mode timing and register block.
// Input channel s_*: one item per transfer, a dot tick, a register read or a
// register write. Result channel m_*: exactly one result per item, in order,
// carrying the read byte and the VBlank and LCD status requests raised.
// A tick advances one dot per clock cycle while the display is on. The
// result of an item is offered once the dots of a tick with the display on
// have been stepped and the item has been finished, and with a ready
// receiver the next input is taken once that result has been loaded.
// The dot stepping unit handles one dot per cycle.
// One item is worked on at a time; a new item is taken once the previous
// one has been placed in the result register, which holds one result.
// When the receiver stalls, the finished result waits in the result
// register, the following item is still taken and worked on, and the block
// then waits with that second result until the first transfer completes.
// Reset (aresetn low, synchronous) clears the registers to their reset
// values: palettes to their defaults, everything else to zero, mode HBlank,
// display off, with both channels empty.
module lcd_mode_timing_and_registers_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode[1:0], address[17:2], write_data[25:18], tick_dots[31:26]
    input  logic [lmt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_data[7:0], vblank_request[8], stat_request[9], zeros above
    output logic [lmt_pkg::M_TDATA_W-1:0] m_tdata
);

    lmt_pkg::lmt_cmd_t cmd;
    lmt_pkg::lmt_sts_t sts;

    // Sequencer.
    lmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Registers, dot timing and result register.
    lmt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule
